// ===== rtl/sscg_pkg.sv =====
// Shared types and constants for the swept sine chirp generator.
`timescale 1ns / 1ps
package sscg_pkg;

  localparam int MUL_W = 32;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_START = 3'd1,
    REG_SPAN  = 3'd2,
    REG_INV   = 3'd3,
    REG_RATIO = 3'd4,
    REG_AMP   = 3'd5,
    REG_TOTAL = 3'd6
  } sscg_reg_t;

  localparam logic [1:0] MODE_LOG  = 2'd0;
  localparam logic [1:0] MODE_QUAD = 2'd1;
  localparam logic [1:0] MODE_LIN  = 2'd2;

  localparam logic [1:0]  RST_MODE  = 2'd0;
  localparam logic [31:0] RST_START = 32'd19522579;
  localparam logic [31:0] RST_SPAN  = 32'd2127961069;
  localparam logic [31:0] RST_INV   = 32'd97391;
  localparam logic [47:0] RST_RATIO = 48'd70368744177664;
  localparam logic [15:0] RST_AMP   = 16'd32768;
  localparam logic [24:0] RST_TOTAL = 25'd44100;

  localparam logic [31:0] POLY_S1 = 32'd1686629713;
  localparam logic [31:0] POLY_S3 = 32'd693598672;
  localparam logic [31:0] POLY_S5 = 32'd85569306;
  localparam logic [31:0] POLY_S7 = 32'd5026995;
  localparam logic [31:0] POLY_S9 = 32'd172272;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ZZ,
    ST_W,
    ST_P9,
    ST_P7T,
    ST_P7M,
    ST_P5T,
    ST_P5M,
    ST_P3T,
    ST_P3M,
    ST_P1T,
    ST_ZP,
    ST_T,
    ST_AMP,
    ST_M,
    ST_HI,
    ST_UPD
  } sscg_state_t;

endpackage

// ===== rtl/sscg_mul.sv =====
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
module sscg_mul
  import sscg_pkg::*;
(
  input  logic                 clk,
  input  logic [MUL_W-1:0]     op_a,
  input  logic [MUL_W-1:0]     op_b,
  output logic [2*MUL_W-1:0]   prod_r
);

  logic [2*MUL_W-1:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

// ===== rtl/swept_sine_chirp_generator.sv =====
// Top level of the swept sine chirp generator.
//
// Input channel in_valid/in_ready carries one item per sample tick; its
// in_restart bit clears phase, index and the log step before the sample.
// Output channel out_valid/out_ready returns one item per input item:
// out_sample (signed Q1.15) and out_last on the final sample of a sweep.
// Configuration is a write port: cfg_we, cfg_addr (register index) and
// cfg_wdata; writes take effect at once, unknown indexes are ignored.
//
// Each item runs through the state sequence from acceptance to its result
// register: one 32x32 multiplier is shared by the sine polynomial, the
// sweep law and the four partial products of the log step, and a dependent
// product passes operand select, then the product register. The idle state
// follows; a new item is accepted only there, never while one is in work.
// in_ready is high in the idle state, also while a result waits; a stalled
// receiver holds the next item in the update step until the result is
// taken. Reset loads the register defaults and clears phase and index.
`timescale 1ns / 1ps
module swept_sine_chirp_generator
  import sscg_pkg::*;
#(
  parameter int SINE_TABLE_ADDR_BITS = 10,
  parameter int SAMPLE_BITS          = 16
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_sample,
  output logic               out_last,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [47:0]        cfg_wdata
);

  localparam int AB   = SINE_TABLE_ADDR_BITS;
  localparam int SB   = SAMPLE_BITS;
  localparam int LOWZ = 32 - AB;
  localparam int TW   = SB - 1;
  localparam logic [29:0] ZMASK = {{(AB-2){1'b1}}, {LOWZ{1'b0}}};
  localparam logic [31:0] T_RND = 32'd1 << (30 - SB);
  localparam logic [31:0] T_MAX = (32'd1 << (SB - 1)) - 32'd1;
  localparam logic [63:0] M_RND = 64'd1 << (SB - 2);

  sscg_state_t state_r, state_nxt;

  logic [1:0]  mode_r;
  logic [31:0] start_r, span_r, inv_r;
  logic [47:0] ratio_r;
  logic [15:0] amp_r;
  logic [24:0] total_r;

  logic [31:0] phase_r;
  logic [24:0] idx_r;
  logic [47:0] step_r;

  logic        quad_r;
  logic [30:0] z_r;
  logic [30:0] w_r;
  logic [31:0] p_r;
  logic [TW-1:0] t_r;
  logic [31:0] x_r, x2_r, lin_r;
  logic [95:0] acc_r;

  logic        out_valid_r, out_last_r;
  logic [15:0] smp_r;

  logic [31:0] op_a, op_b;
  logic [63:0] mul_p;

  logic        accept, fire;
  logic [31:0] phase_start;
  logic [29:0] zpos;
  logic [30:0] z_nxt;
  logic [31:0] s_full, s_clamp, t_sum, t_sh;
  logic [TW-1:0] t_nxt;
  logic [63:0] m_sum, m_v;
  logic [15:0] smp_nxt;
  logic [47:0] step_scaled;
  logic [31:0] inc;
  logic        last_w;

  sscg_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (mul_p)
  );

  assign accept = in_valid && in_ready;
  assign fire   = (state_r == ST_UPD) && (!out_valid_r || out_ready);

  assign phase_start = in_restart ? 32'd0 : phase_r;
  assign zpos        = phase_start[29:0] & ZMASK;
  assign z_nxt       = phase_start[30] ? (ONE_Q30[30:0] - {1'b0, zpos}) : {1'b0, zpos};

  assign s_full  = mul_p[61:30];
  assign s_clamp = (s_full > ONE_Q30) ? ONE_Q30 : s_full;
  assign t_sum   = s_clamp + T_RND;
  assign t_sh    = t_sum >> (31 - SB);
  assign t_nxt   = (t_sh > T_MAX) ? T_MAX[TW-1:0] : t_sh[TW-1:0];

  assign m_sum = mul_p + M_RND;
  assign m_v   = m_sum >> (SB - 1);

  always_comb begin
    if (quad_r) begin
      smp_nxt = (m_v > 64'd32768) ? 16'h8000 : (16'd0 - m_v[15:0]);
    end else begin
      smp_nxt = (m_v > 64'd32767) ? 16'h7FFF : m_v[15:0];
    end
  end

  assign step_scaled = (|acc_r[95:94]) ? 48'hFFFF_FFFF_FFFF : acc_r[93:46];
  assign inc    = (mode_r == MODE_LOG) ? step_r[47:16] : (start_r + lin_r);
  assign last_w = ({1'b0, idx_r} + 26'd1) >= {1'b0, total_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_ZZ;
      ST_ZZ:   state_nxt = ST_W;
      ST_W:    state_nxt = ST_P9;
      ST_P9:   state_nxt = ST_P7T;
      ST_P7T:  state_nxt = ST_P7M;
      ST_P7M:  state_nxt = ST_P5T;
      ST_P5T:  state_nxt = ST_P5M;
      ST_P5M:  state_nxt = ST_P3T;
      ST_P3T:  state_nxt = ST_P3M;
      ST_P3M:  state_nxt = ST_P1T;
      ST_P1T:  state_nxt = ST_ZP;
      ST_ZP:   state_nxt = ST_T;
      ST_T:    state_nxt = ST_AMP;
      ST_AMP:  state_nxt = ST_M;
      ST_M:    state_nxt = ST_HI;
      ST_HI:   state_nxt = ST_UPD;
      ST_UPD:  if (fire) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op_a     = 32'd0;
    op_b     = 32'd0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_ZZ: begin
        op_a = {1'b0, z_r};
        op_b = {1'b0, z_r};
      end
      ST_W: begin
        op_a = {7'd0, idx_r};
        op_b = inv_r;
      end
      ST_P9: begin
        op_a = {1'b0, w_r};
        op_b = POLY_S9;
      end
      ST_P7T: begin
        op_a = x_r;
        op_b = x_r;
      end
      ST_P5T: begin
        op_a = span_r;
        op_b = (mode_r == MODE_QUAD) ? x2_r : x_r;
      end
      ST_P7M, ST_P5M, ST_P3M: begin
        op_a = {1'b0, w_r};
        op_b = p_r;
      end
      ST_P3T: begin
        op_a = {8'd0, step_r[23:0]};
        op_b = {8'd0, ratio_r[23:0]};
      end
      ST_P1T: begin
        op_a = {8'd0, step_r[47:24]};
        op_b = {8'd0, ratio_r[23:0]};
      end
      ST_ZP: begin
        op_a = {1'b0, z_r};
        op_b = p_r;
      end
      ST_T: begin
        op_a = {8'd0, step_r[23:0]};
        op_b = {8'd0, ratio_r[47:24]};
      end
      ST_AMP: begin
        op_a = 32'(t_r);
        op_b = {16'd0, amp_r};
      end
      ST_M: begin
        op_a = {8'd0, step_r[47:24]};
        op_b = {8'd0, ratio_r[47:24]};
      end
      default: begin
        op_a = 32'd0;
        op_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= RST_MODE;
      start_r <= RST_START;
      span_r  <= RST_SPAN;
      inv_r   <= RST_INV;
      ratio_r <= RST_RATIO;
      amp_r   <= RST_AMP;
      total_r <= RST_TOTAL;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_MODE:  mode_r  <= cfg_wdata[1:0];
        REG_START: start_r <= cfg_wdata[31:0];
        REG_SPAN:  span_r  <= cfg_wdata[31:0];
        REG_INV:   inv_r   <= cfg_wdata[31:0];
        REG_RATIO: ratio_r <= cfg_wdata;
        REG_AMP:   amp_r   <= cfg_wdata[15:0];
        REG_TOTAL: total_r <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 32'd0;
      idx_r   <= 25'd0;
      step_r  <= {RST_START, 16'd0};
    end else if (accept) begin
      if (in_restart) begin
        phase_r <= 32'd0;
        idx_r   <= 25'd0;
        step_r  <= {start_r, 16'd0};
      end
    end else if (fire) begin
      phase_r <= phase_r + inc;
      if (last_w) begin
        idx_r  <= 25'd0;
        step_r <= {start_r, 16'd0};
      end else begin
        idx_r <= idx_r + 25'd1;
        if (mode_r == MODE_LOG) begin
          step_r <= step_scaled;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      quad_r <= phase_start[31];
      z_r    <= z_nxt;
    end
    case (state_r)
      ST_W:   w_r   <= mul_p[60:30];
      ST_P9: begin
        x_r <= (|mul_p[63:32]) ? 32'hFFFF_FFFF : mul_p[31:0];
      end
      ST_P7T: p_r   <= POLY_S7 - mul_p[61:30];
      ST_P7M: x2_r  <= mul_p[63:32];
      ST_P5T: p_r   <= POLY_S5 - mul_p[61:30];
      ST_P5M: lin_r <= mul_p[63:32];
      ST_P3T: p_r   <= POLY_S3 - mul_p[61:30];
      ST_P3M: acc_r <= {48'd0, mul_p[47:0]};
      ST_P1T: p_r   <= POLY_S1 - mul_p[61:30];
      ST_ZP:  acc_r <= acc_r + (96'(mul_p[47:0]) << 24);
      ST_T:   t_r   <= t_nxt;
      ST_AMP: acc_r <= acc_r + (96'(mul_p[47:0]) << 24);
      ST_M:   smp_r <= smp_nxt;
      ST_HI:  acc_r <= acc_r + (96'(mul_p[47:0]) << 48);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_last_r <= last_w;
    end
  end

  logic [15:0] out_smp_r;

  always_ff @(posedge clk) begin
    if (fire) begin
      out_smp_r <= smp_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_smp_r;
  assign out_last   = out_last_r;

  a_rose_from_upd: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_UPD))
    else $error("result appeared outside the update step");

  a_upd_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> state_r == ST_IDLE && out_valid_r)
    else $error("update step did not hand off its result");

  a_phase_moves: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(phase_r) |-> $past(fire || (accept && in_restart)))
    else $error("phase changed outside restart or update");

endmodule
